/* hw/rtl/saq_pkg.sv */
// Shared types, sizes and codes for the sequenced aging topic queue.
`default_nettype none

package saq_pkg;

  localparam int NUM_TOPICS  = 4;
  localparam int DEPTH       = 4;

  localparam int TOPIC_W     = (NUM_TOPICS > 1) ? $clog2(NUM_TOPICS) : 1;
  localparam int SLOT_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int STORE_DEPTH = NUM_TOPICS * DEPTH;
  localparam int STORE_W     = $clog2(STORE_DEPTH);

  // Command codes
  localparam logic [1:0] CMD_PUT  = 2'd0;
  localparam logic [1:0] CMD_GET  = 2'd1;
  localparam logic [1:0] CMD_POP  = 2'd2;
  localparam logic [1:0] CMD_TICK = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_UPTODATE = 3'd3;
  localparam logic [2:0] ST_YOUNG    = 3'd4;
  localparam logic [2:0] ST_MOVED    = 3'd5;

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  topic;
    logic [15:0] payload;
    logic [7:0]  publisher_id;
    logic [31:0] last_seen;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] entry_number;
    logic [15:0] entry_payload;
    logic [7:0]  entry_publisher;
    logic [31:0] entry_time;
  } result_t;

  typedef struct packed {
    logic [31:0] number;
    logic [31:0] stamp;
    logic [15:0] payload;
    logic [7:0]  publisher;
  } entry_t;

  typedef struct packed {
    logic               en;
    logic [STORE_W-1:0] addr;
    entry_t             data;
  } store_wr_t;

endpackage

`default_nettype wire

/* hw/rtl/saq_entry_store.sv */
// Generic RAM with one write port and one registered read port.
`default_nettype none

module saq_entry_store #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Contents are undefined until written; a read in the cycle of a write returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/sequenced_aging_topic_queue.sv */
// Top level of the sequenced aging topic queue.
// A command taken is held in the command register; its result is then registered, with done high.
// Throughput: one command per cycle while busy is low; the per-topic ring state is updated in the result stage.
// Results cannot be held off: each is on the result port for exactly one cycle.
// Reset is synchronous: rings empty, counters and time zero, age_limit one, busy high in reset.
`default_nettype none

module sequenced_aging_topic_queue (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  output logic                 busy,
  input  wire saq_pkg::item_t  item,
  output logic                 done,
  output saq_pkg::result_t     result,
  input  wire                  cfg_we,
  input  wire [15:0]           cfg_wdata
);

  localparam int TW = saq_pkg::TOPIC_W;
  localparam int SW = saq_pkg::SLOT_W;
  localparam int CW = saq_pkg::CNT_W;

  logic [15:0]   age_limit;
  logic [31:0]   time_now;
  logic [SW-1:0] write_slot       [saq_pkg::NUM_TOPICS];
  logic [SW-1:0] read_slot        [saq_pkg::NUM_TOPICS];
  logic [CW-1:0] fill_count       [saq_pkg::NUM_TOPICS];
  logic [31:0]   sequence_counter [saq_pkg::NUM_TOPICS];

  logic            held_valid;
  saq_pkg::item_t  held_item;

  logic [TW-1:0]   tsel;
  logic            topic_ok;
  logic [CW-1:0]   fill;
  logic [SW-1:0]   wslot;
  logic [SW-1:0]   rslot;
  logic [SW-1:0]   wslot_next;
  logic [SW-1:0]   rslot_next;
  logic [31:0]     newest;
  logic [31:0]     oldest;
  logic [31:0]     offset;
  logic            offset_hit;
  logic [31:0]     age;
  logic            age_ok;
  logic            is_empty;
  logic            is_full;

  logic [TW-1:0]   in_tsel;
  logic            in_same;
  logic [CW-1:0]   in_fill;
  logic [SW-1:0]   in_rslot;
  logic [31:0]     in_newest;
  logic [31:0]     in_oldest;
  logic [31:0]     in_offset;
  logic            in_hit;
  logic [SW:0]     pos_sum;
  logic [SW-1:0]   pos;
  logic [SW-1:0]   rd_slot;

  saq_pkg::store_wr_t store_wr;
  logic [saq_pkg::STORE_W-1:0] rd_addr;
  saq_pkg::entry_t   rd_data;
  logic              fwd_valid;
  saq_pkg::entry_t   fwd_data;
  saq_pkg::entry_t   rd_entry;

  saq_pkg::result_t  result_next;
  logic              do_put;
  logic              do_pop;
  logic              do_tick;

  saq_entry_store #(
    .WIDTH ($bits(saq_pkg::entry_t)),
    .DEPTH (saq_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_wr.en),
    .waddr (store_wr.addr),
    .wdata (store_wr.data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // The store is read at the accepting edge, so the slot is found from the ring state
  // as it stands after the update made by the command now in the result stage.
  always_comb begin
    in_tsel   = TW'(item.topic);
    in_same   = (in_tsel == tsel);
    in_fill   = fill_count[in_tsel];
    in_rslot  = read_slot[in_tsel];
    in_newest = sequence_counter[in_tsel];
    if (in_same && do_put) begin
      in_fill   = fill + CW'(1);
      in_newest = newest + 32'd1;
    end
    if (in_same && do_pop) begin
      in_fill  = fill - CW'(1);
      in_rslot = rslot_next;
    end

    in_oldest = in_newest - 32'(in_fill) + 32'd1;
    in_offset = item.last_seen + 32'd1 - in_oldest;
    in_hit    = (in_offset < 32'(in_fill));

    // The offset is below DEPTH on a hit, so one subtract wraps the slot.
    pos_sum = (SW + 1)'(in_rslot) + (SW + 1)'(in_offset[SW-1:0]);
    pos     = (pos_sum >= (SW + 1)'(saq_pkg::DEPTH)) ?
              SW'(pos_sum - (SW + 1)'(saq_pkg::DEPTH)) : SW'(pos_sum);

    rd_slot = ((item.command == saq_pkg::CMD_GET) && in_hit) ? pos : in_rslot;
    rd_addr = saq_pkg::STORE_W'(int'(in_tsel) * saq_pkg::DEPTH + int'(rd_slot));
  end

  // A put to the slot being read in the same cycle is passed straight through.
  assign rd_entry = fwd_valid ? fwd_data : rd_data;

  // Ring bookkeeping for the addressed topic.
  always_comb begin
    tsel     = TW'(held_item.topic);
    topic_ok = (int'(held_item.topic) < saq_pkg::NUM_TOPICS);
    fill     = fill_count[tsel];
    wslot    = write_slot[tsel];
    rslot    = read_slot[tsel];
    newest   = sequence_counter[tsel];
    is_empty = (fill == '0);
    is_full  = (fill == CW'(saq_pkg::DEPTH));

    wslot_next = (wslot == SW'(saq_pkg::DEPTH - 1)) ? '0 : wslot + SW'(1);
    rslot_next = (rslot == SW'(saq_pkg::DEPTH - 1)) ? '0 : rslot + SW'(1);

    // Offset of the wanted entry from the oldest one held, modulo 2^32.
    oldest     = newest - 32'(fill) + 32'd1;
    offset     = held_item.last_seen + 32'd1 - oldest;
    offset_hit = (offset < 32'(fill));

    age    = time_now - rd_entry.stamp;
    age_ok = (age >= {16'd0, age_limit});
  end

  // Command execution.
  always_comb begin
    result_next = '0;
    store_wr    = '0;
    do_put      = 1'b0;
    do_pop      = 1'b0;
    do_tick     = 1'b0;

    if (held_valid) begin
      unique case (held_item.command)
        saq_pkg::CMD_TICK: begin
          result_next.status     = saq_pkg::ST_OK;
          result_next.entry_time = time_now + 32'd1;
          do_tick                = 1'b1;
        end
        saq_pkg::CMD_PUT: begin
          if (!topic_ok || is_full) begin
            result_next.status = saq_pkg::ST_FULL;
          end else begin
            result_next.status          = saq_pkg::ST_OK;
            result_next.entry_number    = newest + 32'd1;
            result_next.entry_payload   = held_item.payload;
            result_next.entry_publisher = held_item.publisher_id;
            result_next.entry_time      = time_now;
            store_wr.en                 = 1'b1;
            store_wr.addr = saq_pkg::STORE_W'(int'(tsel) * saq_pkg::DEPTH + int'(wslot));
            store_wr.data.number        = newest + 32'd1;
            store_wr.data.stamp         = time_now;
            store_wr.data.payload       = held_item.payload;
            store_wr.data.publisher     = held_item.publisher_id;
            do_put                      = 1'b1;
          end
        end
        saq_pkg::CMD_GET: begin
          if (!topic_ok || is_empty) begin
            result_next.status = saq_pkg::ST_EMPTY;
          end else if (held_item.last_seen == newest) begin
            result_next.status = saq_pkg::ST_UPTODATE;
          end else begin
            result_next.status          = offset_hit ? saq_pkg::ST_OK : saq_pkg::ST_MOVED;
            result_next.entry_number    = rd_entry.number;
            result_next.entry_payload   = rd_entry.payload;
            result_next.entry_publisher = rd_entry.publisher;
            result_next.entry_time      = rd_entry.stamp;
          end
        end
        saq_pkg::CMD_POP: begin
          if (!topic_ok || is_empty) begin
            result_next.status = saq_pkg::ST_EMPTY;
          end else begin
            result_next.status          = age_ok ? saq_pkg::ST_OK : saq_pkg::ST_YOUNG;
            result_next.entry_number    = rd_entry.number;
            result_next.entry_payload   = rd_entry.payload;
            result_next.entry_publisher = rd_entry.publisher;
            result_next.entry_time      = rd_entry.stamp;
            do_pop                      = age_ok;
          end
        end
        default: begin
          result_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b1;
      held_valid <= 1'b0;
      done       <= 1'b0;
      age_limit  <= 16'd1;
      time_now   <= '0;
      for (int i = 0; i < saq_pkg::NUM_TOPICS; i++) begin
        write_slot[i]       <= '0;
        read_slot[i]        <= '0;
        fill_count[i]       <= '0;
        sequence_counter[i] <= '0;
      end
    end else begin
      busy       <= 1'b0;
      held_valid <= start && !busy;
      done       <= held_valid;
      if (cfg_we) begin
        age_limit <= cfg_wdata;
      end
      if (do_tick) begin
        time_now <= time_now + 32'd1;
      end
      if (do_put) begin
        sequence_counter[tsel] <= newest + 32'd1;
        write_slot[tsel]       <= wslot_next;
        fill_count[tsel]       <= fill + CW'(1);
      end
      if (do_pop) begin
        read_slot[tsel]  <= rslot_next;
        fill_count[tsel] <= fill - CW'(1);
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      held_item <= item;
    end
    fwd_valid <= store_wr.en && (store_wr.addr == rd_addr);
    fwd_data  <= store_wr.data;
    result    <= result_next;
  end

endmodule

`default_nettype wire

/* hw/rtl/saq_checker.sv */
// Port-level checks for the sequenced aging topic queue, bound to the top level.
`default_nettype none

module saq_checker (
  input wire                   clk,
  input wire                   rst,
  input wire                   start,
  input wire                   busy,
  input wire                   done,
  input wire saq_pkg::result_t result
);

  // Every transfer in gives exactly one result, with done high.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted command produced no result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without an accepted command");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status <= saq_pkg::ST_MOVED))
    else $error("undefined status code");

  // Full, empty and up-to-date answers carry no entry.
  a_blank_entry: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == saq_pkg::ST_FULL || result.status == saq_pkg::ST_EMPTY ||
              result.status == saq_pkg::ST_UPTODATE))
    |-> (result.entry_number == 32'd0 && result.entry_payload == 16'd0 &&
         result.entry_publisher == 8'd0 && result.entry_time == 32'd0))
    else $error("entry fields not cleared on a refusal");

endmodule

bind sequenced_aging_topic_queue saq_checker u_saq_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .result    (result)
);

`default_nettype wire
